// ----- rtl/mrdam_pkg.sv -----
// Package for the multichannel rate-divided audio mixer.
// Holds field widths, event and register codes, the channel record layout and divider types.
// No dependencies.
package mrdam_pkg;

	localparam int MAX_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS      = 8;

	localparam int OP_W      = 4;
	localparam int CH_W      = 3;
	localparam int VOL_W     = 8;
	localparam int FREQ_W    = 16;
	localparam int RATE_W    = 32;
	localparam int STATE_W   = 2;
	localparam int AUTO_W    = 4;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [OP_W-1:0] OP_TICK      = 4'd0;
	localparam logic [OP_W-1:0] OP_PLAY      = 4'd1;
	localparam logic [OP_W-1:0] OP_STOP      = 4'd2;
	localparam logic [OP_W-1:0] OP_PAUSE     = 4'd3;
	localparam logic [OP_W-1:0] OP_RESUME    = 4'd4;
	localparam logic [OP_W-1:0] OP_VOLUME    = 4'd5;
	localparam logic [OP_W-1:0] OP_SAMPLE    = 4'd6;
	localparam logic [OP_W-1:0] OP_FREQ      = 4'd7;
	localparam logic [OP_W-1:0] OP_END       = 4'd8;
	localparam logic [OP_W-1:0] OP_PLAY_AUTO = 4'd9;

	localparam logic [STATE_W-1:0] CH_STOPPED = 2'd0;
	localparam logic [STATE_W-1:0] CH_PLAYING = 2'd1;
	localparam logic [STATE_W-1:0] CH_PAUSED  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_AUTO    = 1'b1;

	localparam logic [CFG_W-1:0]       COUNT_RESET = 4'd8;
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE  = 8'd255;
	localparam logic [RATE_W-1:0]      RATE_MAX    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [VOL_W-1:0]       vol;
		logic [SAMPLE_BITS-1:0] held;
		logic [SAMPLE_BITS-1:0] pval;
		logic [FREQ_W-1:0]      freq;
		logic [RATE_W-1:0]      div;
	} chrec_t;

	localparam chrec_t REC_RESET = '{vol: 8'd255, held: 8'd0, pval: 8'd0, freq: 16'd0,
		div: 32'd1};

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [31:0] rem;
	} div_rsp_t;

	function automatic logic [31:0] eff_freq(input logic [FREQ_W-1:0] f);
		return (f == '0) ? 32'd1 : {16'd0, f};
	endfunction

	function automatic logic [7:0] eff_count(input logic [CFG_W-1:0] c, input logic [7:0] maxc);
		logic [7:0] c8;
		c8 = {4'd0, c};
		if (c8 == 8'd0)
			c8 = 8'd1;
		if (c8 > maxc)
			c8 = maxc;
		return c8;
	endfunction

endpackage

// ----- rtl/mrdam_div.sv -----
// Iterative 32/32 unsigned divider, one quotient bit per cycle.
// Uses mrdam_pkg for request and response types.
module mrdam_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mrdam_pkg::div_req_t req,
	output mrdam_pkg::div_rsp_t rsp
);
	import mrdam_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic        fits;

	always_comb begin
		shifted = {rem_q, quo_q[31]};
		fits    = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
				quo_q <= {quo_q[30:0], fits};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{done: done_q, quot: quo_q, rem: rem_q};

endmodule

// ----- rtl/multichannel_rate_divided_audio_mixer_unit.sv -----
// Top level of the multichannel rate-divided audio mixer: event sequencer over a channel record memory.
// Depends on mrdam_pkg and mrdam_div.
//
//   channel  | direction | handshake            | word
//   in       | input     | in_valid / in_ready  | operation .. repeat_req
//   out      | output    | out_valid / out_ready| dac_level .. rate_overflow
//   cfg      | input     | cfg_we, no wait      | cfg_index, cfg_data
//
// One word at a time. Events that touch no rate go from S_EXEC to S_OUT and the output hand-off.
// A tick visits each active channel, with a divider pass for any divisor other than 1,
// plus a pass of the shared divider for the level division.
// A rate change walks the record memory twice; each lcm costs one divider pass
// per Euclid step plus one for the quotient. Reset needs no clearing pass.
// A waiting result does not block the next word from being accepted.
module multichannel_rate_divided_audio_mixer_unit #(
	parameter int MAX_CHANNELS = mrdam_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [mrdam_pkg::OP_W-1:0]             operation,
	input  logic [mrdam_pkg::CH_W-1:0]             channel,
	input  logic [mrdam_pkg::VOL_W-1:0]            volume,
	input  logic [mrdam_pkg::SAMPLE_BITS-1:0]      sample_value,
	input  logic [mrdam_pkg::FREQ_W-1:0]           frequency,
	input  logic                                   repeat_req,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mrdam_pkg::SAMPLE_BITS-1:0]      dac_level,
	output logic [mrdam_pkg::RATE_W-1:0]           common_rate,
	output logic                                   running,
	output logic [mrdam_pkg::STATE_W-1:0]          channel_state,
	output logic [mrdam_pkg::AUTO_W-1:0]           auto_channel,
	output logic [mrdam_pkg::VOL_W-1:0]            volume_readback,
	output logic                                   sample_dropped,
	output logic                                   rate_overflow,
	input  logic                                   cfg_we,
	input  logic [mrdam_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mrdam_pkg::CFG_W-1:0]            cfg_data
);
	import mrdam_pkg::*;

	localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW = $clog2(MAX_CHANNELS + 1);
	localparam int SUMW = 2 * SAMPLE_BITS + CW;
	localparam logic [CW-1:0] IDX_END = CW'(MAX_CHANNELS);
	localparam logic [7:0] MAX8 = 8'(MAX_CHANNELS);

	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_RA_RD, S_RA_DAT, S_G_CHK, S_G_WAIT, S_L_DIV, S_L_SAT,
		S_RB_INIT, S_RB_RD, S_RB_DAT, S_RB_DIVW, S_RC_FIN,
		S_T_RD, S_T_DAT, S_T_DW, S_T_APPLY, S_T_DIV, S_T_DSW, S_OUT
	} state_t;

	typedef enum logic {RET_RATE, RET_PERIOD} ret_t;

	state_t state_q;
	ret_t   ret_q;

	logic [MAX_CHANNELS-1:0] act_q, pau_q, pv_q, init_q;
	logic [CFG_W-1:0]        count_q, fa_q;
	logic                    cfg_pend_q;

	logic [OP_W-1:0]        op_q;
	logic [VOL_W-1:0]       vol_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic [FREQ_W-1:0]      freq_q;
	logic                   rep_q;
	logic [IW-1:0]          tgt_q;
	logic                   tv_q;
	logic [AUTO_W-1:0]      autoch_q;
	logic                   drop_q;
	logic [VOL_W-1:0]       volo_q;
	logic [SAMPLE_BITS-1:0] dac_q;
	logic                   clr_q;
	logic                   has_res_q;

	logic [CW-1:0]     idx_q;
	logic [RATE_W-1:0] l_q, p_q, ga_q, gb_q, lx_q, ly_q;
	logic [63:0]       prod_q;
	logic              hit_q;
	logic [SUMW-1:0]   sum_q;
	logic [RATE_W-1:0] tick_q, period_q, rate_q;
	logic [CW-1:0]     active_q;
	logic              ovf_q;

	div_req_t div_req_q;
	div_rsp_t div_rsp;

	chrec_t mem [MAX_CHANNELS];
	chrec_t rd_q;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] dac_level_q;
	logic [RATE_W-1:0]      common_rate_q;
	logic                   running_q;
	logic [STATE_W-1:0]     channel_state_q;
	logic [AUTO_W-1:0]      auto_channel_q;
	logic [VOL_W-1:0]       volume_readback_q;
	logic                   sample_dropped_q;
	logic                   rate_overflow_q;

	logic [7:0]        cnt8, ch8, sel8, in_tgt8, new_cnt8;
	logic              found, in_tv, in_fire;
	logic [IW-1:0]     idx_addr, in_addr;
	logic              idx_end, act_idx;
	logic [CW-1:0]     n_active;
	logic [RATE_W-1:0] rd_f, d_n, lcm_res;
	logic              lcm_ovf;
	logic [63:0]       prod_n;
	logic              take;
	logic [SAMPLE_BITS-1:0] held_n;
	logic [2*SAMPLE_BITS-1:0] term;
	logic [STATE_W-1:0] st_n;

	logic              mem_re, mem_we;
	logic [IW-1:0]     mem_ra, mem_wa;
	chrec_t            mem_wd;

	chrec_t ex_rec;
	logic   ex_wr, ex_rc, ex_clr, ex_drop, ex_act, ex_pau, ex_pv;

	mrdam_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	always_comb begin
		cnt8     = eff_count(count_q, MAX8);
		new_cnt8 = eff_count(cfg_data, MAX8);
		ch8      = {5'd0, channel};
		found    = 1'b0;
		sel8     = '0;
		for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
			if (8'(i) >= {4'd0, fa_q} && 8'(i) < cnt8 && !act_q[i] && !pau_q[i]) begin
				found = 1'b1;
				sel8  = 8'(i);
			end
		end
		in_ready = (state_q == S_IDLE) && !cfg_pend_q;
		in_fire  = in_valid && in_ready;
		in_tgt8  = (operation == OP_PLAY_AUTO) ? sel8 : ch8;
		in_tv    = (operation == OP_PLAY_AUTO) ? found : (ch8 < cnt8);
		in_addr  = in_tgt8[IW-1:0];
		idx_addr = idx_q[IW-1:0];
		idx_end  = idx_q == IDX_END;
		act_idx  = act_q[idx_addr];
		n_active = '0;
		for (int i = 0; i < MAX_CHANNELS; i++)
			n_active = n_active + CW'(act_q[i]);
		rd_f    = eff_freq(rd_q.freq);
		d_n     = (div_rsp.quot == '0) ? 32'd1 : div_rsp.quot;
		prod_n  = 64'(div_rsp.quot) * 64'(ly_q);
		lcm_ovf = prod_q > {32'd0, RATE_MAX};
		lcm_res = lcm_ovf ? RATE_MAX : prod_q[31:0];
		take    = hit_q && pv_q[idx_addr];
		held_n  = take ? rd_q.pval : rd_q.held;
		term    = {8'd0, held_n} * {8'd0, rd_q.vol};
		st_n    = CH_STOPPED;
		if (tv_q) begin
			if (act_q[tgt_q])
				st_n = CH_PLAYING;
			else if (pau_q[tgt_q])
				st_n = CH_PAUSED;
		end
	end

	// event decode against the record of the addressed channel
	always_comb begin
		ex_rec  = rd_q;
		ex_wr   = 1'b0;
		ex_rc   = 1'b0;
		ex_clr  = 1'b0;
		ex_drop = 1'b0;
		ex_act  = act_q[tgt_q];
		ex_pau  = pau_q[tgt_q];
		ex_pv   = pv_q[tgt_q];
		unique case (op_q)
			OP_PLAY, OP_PLAY_AUTO: begin
				if (tv_q) begin
					ex_rec.held = '0;
					ex_rec.freq = freq_q;
					if (op_q == OP_PLAY_AUTO)
						ex_rec.vol = vol_q;
					ex_wr  = 1'b1;
					ex_act = 1'b1;
					ex_pau = 1'b0;
					ex_pv  = 1'b0;
					ex_rc  = 1'b1;
					ex_clr = 1'b1;
				end
			end
			OP_STOP: begin
				if (tv_q && (act_q[tgt_q] || pau_q[tgt_q])) begin
					ex_act = 1'b0;
					ex_pau = 1'b0;
					ex_pv  = 1'b0;
					ex_rc  = act_q[tgt_q];
					ex_clr = act_q[tgt_q];
				end
			end
			OP_PAUSE: begin
				if (tv_q && act_q[tgt_q]) begin
					ex_act = 1'b0;
					ex_pau = 1'b1;
					ex_rc  = 1'b1;
					ex_clr = 1'b1;
				end
			end
			OP_RESUME: begin
				if (tv_q && pau_q[tgt_q]) begin
					ex_act = 1'b1;
					ex_pau = 1'b0;
					ex_rc  = 1'b1;
					ex_clr = 1'b1;
				end
			end
			OP_VOLUME: begin
				if (tv_q) begin
					ex_rec.vol = vol_q;
					ex_wr      = 1'b1;
				end
			end
			OP_SAMPLE: begin
				if (!tv_q || !(act_q[tgt_q] || pau_q[tgt_q]) || pv_q[tgt_q]) begin
					ex_drop = 1'b1;
				end else begin
					ex_rec.pval = smp_q;
					ex_wr       = 1'b1;
					ex_pv       = 1'b1;
				end
			end
			OP_FREQ: begin
				if (tv_q && (act_q[tgt_q] || pau_q[tgt_q])) begin
					ex_rec.freq = freq_q;
					ex_wr       = 1'b1;
					ex_rc       = act_q[tgt_q];
				end
			end
			OP_END: begin
				if (tv_q && act_q[tgt_q] && !rep_q) begin
					ex_act = 1'b0;
					ex_pau = 1'b0;
					ex_pv  = 1'b0;
					ex_rc  = 1'b1;
					ex_clr = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_re = 1'b0;
		mem_ra = idx_addr;
		mem_we = 1'b0;
		mem_wa = idx_addr;
		mem_wd = rd_q;
		unique case (state_q)
			S_IDLE: begin
				mem_re = in_fire;
				mem_ra = in_addr;
			end
			S_EXEC: begin
				mem_we = ex_wr;
				mem_wa = tgt_q;
				mem_wd = ex_rec;
			end
			S_RA_RD, S_T_RD: mem_re = !idx_end && act_idx;
			S_RB_RD:         mem_re = !idx_end;
			S_RB_DAT: begin
				mem_we     = !act_idx;
				mem_wd.div = 32'd1;
			end
			S_RB_DIVW: begin
				mem_we     = div_rsp.done;
				mem_wd.div = d_n;
			end
			S_T_APPLY: begin
				mem_we      = take;
				mem_wd.held = rd_q.pval;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= init_q[mem_ra] ? mem[mem_ra] : REC_RESET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			ret_q             <= RET_RATE;
			act_q             <= '0;
			pau_q             <= '0;
			pv_q              <= '0;
			init_q            <= '0;
			count_q           <= COUNT_RESET;
			fa_q              <= '0;
			cfg_pend_q        <= 1'b0;
			op_q              <= OP_TICK;
			vol_q             <= '0;
			smp_q             <= '0;
			freq_q            <= '0;
			rep_q             <= 1'b0;
			tgt_q             <= '0;
			tv_q              <= 1'b0;
			autoch_q          <= '0;
			drop_q            <= 1'b0;
			volo_q            <= '0;
			dac_q             <= '0;
			clr_q             <= 1'b0;
			has_res_q         <= 1'b0;
			idx_q             <= '0;
			l_q               <= 32'd1;
			p_q               <= 32'd1;
			ga_q              <= '0;
			gb_q              <= '0;
			lx_q              <= '0;
			ly_q              <= '0;
			prod_q            <= '0;
			hit_q             <= 1'b0;
			sum_q             <= '0;
			tick_q            <= '0;
			period_q          <= 32'd1;
			rate_q            <= '0;
			active_q          <= '0;
			ovf_q             <= 1'b0;
			div_req_q         <= '0;
			out_valid_q       <= 1'b0;
			dac_level_q       <= '0;
			common_rate_q     <= '0;
			running_q         <= 1'b0;
			channel_state_q   <= CH_STOPPED;
			auto_channel_q    <= '0;
			volume_readback_q <= '0;
			sample_dropped_q  <= 1'b0;
			rate_overflow_q   <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (mem_we)
				init_q[mem_wa] <= 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (cfg_pend_q) begin
						cfg_pend_q <= 1'b0;
						has_res_q  <= 1'b0;
						clr_q      <= 1'b1;
						idx_q      <= '0;
						l_q        <= 32'd1;
						ovf_q      <= 1'b0;
						state_q    <= S_RA_RD;
					end else if (in_fire) begin
						op_q      <= operation;
						vol_q     <= volume;
						smp_q     <= sample_value;
						freq_q    <= frequency;
						rep_q     <= repeat_req;
						tgt_q     <= in_addr;
						tv_q      <= in_tv;
						has_res_q <= 1'b1;
						dac_q     <= '0;
						autoch_q  <= (operation == OP_PLAY_AUTO) ?
							(found ? sel8[AUTO_W-1:0] : cnt8[AUTO_W-1:0]) : '0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					act_q[tgt_q] <= ex_act;
					pau_q[tgt_q] <= ex_pau;
					pv_q[tgt_q]  <= ex_pv;
					drop_q       <= ex_drop;
					volo_q       <= tv_q ? ex_rec.vol : '0;
					if (op_q == OP_TICK) begin
						if (active_q != '0) begin
							tick_q  <= (tick_q >= period_q) ? 32'd1 : tick_q + 32'd1;
							idx_q   <= '0;
							sum_q   <= '0;
							state_q <= S_T_RD;
						end else begin
							state_q <= S_OUT;
						end
					end else if (ex_rc) begin
						clr_q   <= ex_clr;
						idx_q   <= '0;
						l_q     <= 32'd1;
						ovf_q   <= 1'b0;
						state_q <= S_RA_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_RA_RD: begin
					if (idx_end)
						state_q <= S_RB_INIT;
					else if (act_idx)
						state_q <= S_RA_DAT;
					else
						idx_q <= idx_q + CW'(1);
				end
				S_RA_DAT: begin
					lx_q    <= l_q;
					ly_q    <= rd_f;
					ga_q    <= l_q;
					gb_q    <= rd_f;
					ret_q   <= RET_RATE;
					state_q <= S_G_CHK;
				end
				S_G_CHK: begin
					div_req_q.start <= 1'b1;
					if (gb_q == '0) begin
						div_req_q.dividend <= lx_q;
						div_req_q.divisor  <= ga_q;
						state_q            <= S_L_DIV;
					end else begin
						div_req_q.dividend <= ga_q;
						div_req_q.divisor  <= gb_q;
						state_q            <= S_G_WAIT;
					end
				end
				S_G_WAIT: begin
					if (div_rsp.done) begin
						ga_q    <= gb_q;
						gb_q    <= div_rsp.rem;
						state_q <= S_G_CHK;
					end
				end
				S_L_DIV: begin
					if (div_rsp.done) begin
						prod_q  <= prod_n;
						state_q <= S_L_SAT;
					end
				end
				S_L_SAT: begin
					if (lcm_ovf)
						ovf_q <= 1'b1;
					idx_q <= idx_q + CW'(1);
					unique case (ret_q)
						RET_RATE: begin
							l_q     <= lcm_res;
							state_q <= S_RA_RD;
						end
						RET_PERIOD: begin
							p_q     <= lcm_res;
							state_q <= S_RB_RD;
						end
					endcase
				end
				S_RB_INIT: begin
					rate_q   <= (n_active == '0) ? '0 : l_q;
					active_q <= n_active;
					idx_q    <= '0;
					p_q      <= 32'd1;
					state_q  <= S_RB_RD;
				end
				S_RB_RD: begin
					state_q <= idx_end ? S_RC_FIN : S_RB_DAT;
				end
				S_RB_DAT: begin
					if (!act_idx) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_RB_RD;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= l_q;
						div_req_q.divisor  <= rd_f;
						state_q            <= S_RB_DIVW;
					end
				end
				S_RB_DIVW: begin
					if (div_rsp.done) begin
						lx_q    <= p_q;
						ly_q    <= d_n;
						ga_q    <= p_q;
						gb_q    <= d_n;
						ret_q   <= RET_PERIOD;
						state_q <= S_G_CHK;
					end
				end
				S_RC_FIN: begin
					period_q <= p_q;
					if (clr_q)
						tick_q <= '0;
					state_q <= has_res_q ? S_OUT : S_IDLE;
				end
				S_T_RD: begin
					if (idx_end)
						state_q <= S_T_DIV;
					else if (act_idx)
						state_q <= S_T_DAT;
					else
						idx_q <= idx_q + CW'(1);
				end
				S_T_DAT: begin
					if (rd_q.div == 32'd1 || rd_q.div == '0) begin
						hit_q   <= rd_q.div == 32'd1;
						state_q <= S_T_APPLY;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= tick_q;
						div_req_q.divisor  <= rd_q.div;
						state_q            <= S_T_DW;
					end
				end
				S_T_DW: begin
					if (div_rsp.done) begin
						hit_q   <= div_rsp.rem == '0;
						state_q <= S_T_APPLY;
					end
				end
				S_T_APPLY: begin
					if (take)
						pv_q[idx_addr] <= 1'b0;
					sum_q   <= sum_q + SUMW'(term);
					idx_q   <= idx_q + CW'(1);
					state_q <= S_T_RD;
				end
				S_T_DIV: begin
					div_req_q.start    <= 1'b1;
					div_req_q.dividend <= 32'(sum_q);
					div_req_q.divisor  <= 32'({8'd0, cnt8} * {8'd0, FULL_SCALE});
					state_q            <= S_T_DSW;
				end
				S_T_DSW: begin
					if (div_rsp.done) begin
						dac_q   <= (div_rsp.quot > 32'(FULL_SCALE)) ? FULL_SCALE :
							div_rsp.quot[SAMPLE_BITS-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						dac_level_q       <= dac_q;
						common_rate_q     <= rate_q;
						running_q         <= active_q != '0;
						channel_state_q   <= st_n;
						auto_channel_q    <= autoch_q;
						volume_readback_q <= volo_q;
						sample_dropped_q  <= drop_q;
						rate_overflow_q   <= ovf_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CHANNEL_COUNT: begin
						count_q    <= cfg_data;
						cfg_pend_q <= 1'b1;
						for (int i = 0; i < MAX_CHANNELS; i++) begin
							if (8'(i) >= new_cnt8) begin
								act_q[i] <= 1'b0;
								pau_q[i] <= 1'b0;
								pv_q[i]  <= 1'b0;
							end
						end
					end
					CFG_FIRST_AUTO: fa_q <= cfg_data;
				endcase
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign dac_level       = dac_level_q;
	assign common_rate     = common_rate_q;
	assign running         = running_q;
	assign channel_state   = channel_state_q;
	assign auto_channel    = auto_channel_q;
	assign volume_readback = volume_readback_q;
	assign sample_dropped  = sample_dropped_q;
	assign rate_overflow   = rate_overflow_q;

endmodule

// ----- rtl/mrdam_chk.sv -----
// Port-level checker for the audio mixer output word, bound to the top level.
// Depends on mrdam_pkg and multichannel_rate_divided_audio_mixer_unit.
module mrdam_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic [mrdam_pkg::SAMPLE_BITS-1:0]      dac_level,
	input logic [mrdam_pkg::RATE_W-1:0]           common_rate,
	input logic                                   running,
	input logic                                   rate_overflow
);
	import mrdam_pkg::*;

	a_idle_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> common_rate == '0)
		else $error("idle word carries a rate");

	a_run_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running |-> common_rate != '0)
		else $error("running word carries zero rate");

	a_idle_dac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> dac_level == '0 && !rate_overflow)
		else $error("idle word carries level or overflow");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(common_rate) && $stable(dac_level))
		else $error("stalled word changed");

endmodule

bind multichannel_rate_divided_audio_mixer_unit mrdam_chk u_mrdam_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.dac_level     (dac_level),
	.common_rate   (common_rate),
	.running       (running),
	.rate_overflow (rate_overflow)
);

// ----- sim/tb.sv -----
// Self-checking bench for the multichannel rate-divided audio mixer.
// Drives event words with bursty valid, stalls the result side, predicts every result word.
// Depends on mrdam_pkg and multichannel_rate_divided_audio_mixer_unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mrdam_pkg::*;

	localparam int NCH = MAX_CHANNELS_DEF;
	localparam longint LIMIT = 50000000;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [CH_W-1:0] ch;
		logic [VOL_W-1:0] vol;
		logic [SAMPLE_BITS-1:0] smp;
		logic [FREQ_W-1:0] freq;
		logic rep;
	} event_t;

	typedef struct packed {
		logic [7:0] dac;
		logic [RATE_W-1:0] rate;
		logic run;
		logic [STATE_W-1:0] st;
		logic [AUTO_W-1:0] autoc;
		logic [VOL_W-1:0] vol;
		logic drop;
		logic ovf;
	} mix_word_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [OP_W-1:0] operation = '0;
	logic [CH_W-1:0] channel = '0;
	logic [VOL_W-1:0] volume = '0;
	logic [SAMPLE_BITS-1:0] sample_value = '0;
	logic [FREQ_W-1:0] frequency = '0;
	logic repeat_req = 0;
	logic [7:0] dac_level;
	logic [RATE_W-1:0] common_rate;
	logic running, sample_dropped, rate_overflow;
	logic [STATE_W-1:0] channel_state;
	logic [AUTO_W-1:0] auto_channel;
	logic [VOL_W-1:0] volume_readback;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	multichannel_rate_divided_audio_mixer_unit dut (.*);

	always #10 clk = ~clk;

	// mixer state mirror
	logic [3:0] m_count, m_first;
	bit m_act[NCH], m_pau[NCH], m_pv[NCH];
	logic [7:0] m_vol[NCH], m_held[NCH], m_pval[NCH];
	logic [15:0] m_freq[NCH];
	logic [31:0] m_div[NCH], m_cnt, m_period, m_rate;
	int m_total;
	bit m_ovf;

	event_t pending_words[$];
	mix_word_t expected_words[$];
	int mismatches = 0, sent = 0;
	bit hold_off = 0, sender_pause = 0, timed_out = 0;
	longint cycles = 0;

	function automatic int eff_cnt();
		int c = m_count;
		if (c == 0) c = 1;
		if (c > NCH) c = NCH;
		return c;
	endfunction

	function automatic longint efreq(int i);
		return m_freq[i] == 0 ? 1 : m_freq[i];
	endfunction

	function automatic longint lcm_sat(longint x, longint y);
		longint a, b, t, r;
		if (x == 0 || y == 0) return 1;
		a = x; b = y;
		while (b != 0) begin t = a % b; a = b; b = t; end
		r = (x / a) * y;
		if (r > 64'hFFFFFFFF) begin m_ovf = 1; r = 64'hFFFFFFFF; end
		return r;
	endfunction

	function automatic void rerate();
		longint l = 1, p = 1, d;
		m_total = 0;
		for (int i = 0; i < NCH; i++) begin m_div[i] = 1; if (m_act[i]) m_total++; end
		m_ovf = 0; m_period = 1;
		if (m_total == 0) begin m_rate = 0; return; end
		if (m_total == 1) begin
			for (int i = 0; i < NCH; i++) if (m_act[i]) m_rate = 32'(efreq(i));
			return;
		end
		for (int i = 0; i < NCH; i++) if (m_act[i]) l = lcm_sat(l, efreq(i));
		m_rate = 32'(l);
		for (int i = 0; i < NCH; i++) if (m_act[i]) begin
			d = l / efreq(i);
			if (d == 0) d = 1;
			m_div[i] = 32'(d);
			p = lcm_sat(p, d);
		end
		m_period = 32'(p);
	endfunction

	function automatic void drop_ch(int i);
		m_act[i] = 0; m_pau[i] = 0; m_pv[i] = 0; m_pval[i] = 0;
	endfunction

	function automatic void start_ch(int i, logic [15:0] f);
		drop_ch(i);
		m_act[i] = 1; m_freq[i] = f; m_held[i] = 0;
		rerate();
		m_cnt = 0;
	endfunction

	function automatic void mirror_reset();
		m_count = COUNT_RESET; m_first = 0;
		for (int i = 0; i < NCH; i++) begin
			drop_ch(i); m_vol[i] = 8'd255; m_held[i] = 0; m_freq[i] = 0; m_div[i] = 1;
		end
		m_cnt = 0; m_period = 1; m_rate = 0; m_total = 0; m_ovf = 0;
	endfunction

	function automatic void mirror_cfg(logic [CFG_IDX_W-1:0] idx, logic [3:0] v);
		if (idx == CFG_CHANNEL_COUNT) begin
			m_count = v;
			for (int i = eff_cnt(); i < NCH; i++) drop_ch(i);
			rerate();
			m_cnt = 0;
		end else m_first = v;
	endfunction

	function automatic mix_word_t mix_predict(event_t e);
		mix_word_t r;
		int cnt = eff_cnt(), ch = e.ch;
		bit ok = ch < cnt;
		longint sum;
		bit was;
		r = '0;
		case (e.op)
			OP_TICK: if (m_total != 0) begin
				sum = 0;
				if (m_cnt >= m_period) m_cnt = 1; else m_cnt++;
				for (int i = 0; i < NCH; i++) if (m_act[i]) begin
					if (m_div[i] != 0 && m_cnt % m_div[i] == 0 && m_pv[i]) begin
						m_held[i] = m_pval[i]; m_pv[i] = 0;
					end
					sum += m_held[i] * m_vol[i];
				end
				sum = sum / 255 / cnt;
				r.dac = 8'(sum > 255 ? 255 : sum);
			end
			OP_PLAY: if (ok) start_ch(ch, e.freq);
			OP_STOP: if (ok && (m_act[ch] || m_pau[ch])) begin
				was = m_act[ch];
				drop_ch(ch);
				if (was) begin rerate(); m_cnt = 0; end
			end
			OP_PAUSE: if (ok && m_act[ch]) begin
				m_act[ch] = 0; m_pau[ch] = 1; rerate(); m_cnt = 0;
			end
			OP_RESUME: if (ok && m_pau[ch]) begin
				m_pau[ch] = 0; m_act[ch] = 1; rerate(); m_cnt = 0;
			end
			OP_VOLUME: if (ok) m_vol[ch] = e.vol;
			OP_SAMPLE: if (!ok || !(m_act[ch] || m_pau[ch]) || m_pv[ch]) r.drop = 1;
				else begin m_pval[ch] = e.smp; m_pv[ch] = 1; end
			OP_FREQ: if (ok && (m_act[ch] || m_pau[ch])) begin
				m_freq[ch] = e.freq;
				if (m_act[ch]) rerate();
			end
			OP_END: if (ok && m_act[ch] && !e.rep) begin
				drop_ch(ch); rerate(); m_cnt = 0;
			end
			OP_PLAY_AUTO: begin
				r.autoc = AUTO_W'(cnt); ok = 0;
				for (int i = m_first; i < cnt; i++) if (!m_act[i] && !m_pau[i]) begin
					m_vol[i] = e.vol; start_ch(i, e.freq);
					r.autoc = AUTO_W'(i); ch = i; ok = 1;
					break;
				end
			end
			default: ;
		endcase
		r.rate = m_rate;
		r.run = m_total != 0;
		r.st = ok ? (m_act[ch] ? CH_PLAYING : (m_pau[ch] ? CH_PAUSED : CH_STOPPED)) : CH_STOPPED;
		r.vol = ok ? m_vol[ch] : 8'd0;
		r.ovf = m_ovf;
		return r;
	endfunction

	// driver: bursts and gaps
	int burst = 0, gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && in_ready) begin
			expected_words.push_back(mix_predict({operation, channel, volume, sample_value,
				frequency, repeat_req}));
			sent <= sent + 1;
		end
		if (!in_valid || in_ready) begin
			if (gap > 0 || sender_pause || pending_words.size() == 0) begin
				in_valid <= 0;
				if (gap > 0) gap <= gap - 1;
			end else begin
				event_t e;
				e = pending_words.pop_front();
				{operation, channel, volume, sample_value, frequency, repeat_req} <= e;
				in_valid <= 1;
				if (burst == 0) begin
					burst <= $urandom_range(1, 20);
					gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else burst <= burst - 1;
			end
		end
	end

	// monitor with its own stall pattern
	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		out_ready <= !hold_off && (stall_phase % 16 < 8 ? 1'b1 : ($urandom_range(0, 2) != 0));
		if (out_valid && out_ready) begin
			mix_word_t got, want;
			got = {dac_level, common_rate, running, channel_state, auto_channel,
				volume_readback, sample_dropped, rate_overflow};
			if (expected_words.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected word %h", got);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: dac %0d/%0d rate %0d/%0d run %b/%b st %0d/%0d auto %0d/%0d vol %0d/%0d drop %b/%b ovf %b/%b",
							want.dac, got.dac, want.rate, got.rate, want.run, got.run,
							want.st, got.st, want.autoc, got.autoc, want.vol, got.vol,
							want.drop, got.drop, want.ovf, got.ovf);
				end
			end
		end
	end

	always @(posedge clk) if (cycles > LIMIT) begin
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [15:0] rand_freq();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 8));
			3: return 16'd1 << $urandom_range(0, 15);
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic event_t rand_event();
		event_t e;
		int k = $urandom_range(0, 99);
		e.ch = CH_W'($urandom); e.vol = VOL_W'($urandom); e.smp = SAMPLE_BITS'($urandom);
		e.freq = rand_freq();
		e.rep = 1'($urandom);
		if (k < 30) e.op = OP_TICK;
		else if (k < 48) e.op = OP_SAMPLE;
		else if (k < 56) e.op = OP_PLAY;
		else if (k < 62) e.op = OP_PLAY_AUTO;
		else if (k < 68) e.op = OP_VOLUME;
		else if (k < 74) e.op = OP_FREQ;
		else if (k < 79) e.op = OP_PAUSE;
		else if (k < 84) e.op = OP_RESUME;
		else if (k < 89) e.op = OP_END;
		else if (k < 94) e.op = OP_STOP;
		else e.op = OP_W'($urandom_range(10, 15));
		return e;
	endfunction

	function automatic event_t mk(logic [3:0] op, int ch, int vol, int smp, int f, bit rep);
		event_t e;
		e.op = op; e.ch = CH_W'(ch); e.vol = VOL_W'(vol); e.smp = SAMPLE_BITS'(smp);
		e.freq = FREQ_W'(f); e.rep = rep;
		return e;
	endfunction

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_words.size() == 0);
		repeat (3000) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [3:0] v);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		mirror_cfg(idx, v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		mirror_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed
		pending_words.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_PLAY, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_SAMPLE, 0, 0, 255, 0, 0));
		pending_words.push_back(mk(OP_SAMPLE, 0, 0, 1, 0, 0));
		pending_words.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_PLAY, 1, 0, 0, 65535, 0));
		pending_words.push_back(mk(OP_PLAY, 2, 0, 0, 65521, 0));
		pending_words.push_back(mk(OP_PLAY, 3, 0, 0, 65519, 0));
		pending_words.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_SAMPLE, 5, 0, 7, 0, 0));
		pending_words.push_back(mk(OP_STOP, 5, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_PAUSE, 1, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_PAUSE, 1, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_FREQ, 1, 0, 0, 440, 0));
		pending_words.push_back(mk(OP_RESUME, 1, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_RESUME, 1, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_VOLUME, 7, 0, 0, 0, 1));
		pending_words.push_back(mk(OP_END, 2, 0, 0, 0, 1));
		pending_words.push_back(mk(OP_END, 2, 0, 0, 0, 0));
		pending_words.push_back(mk(OP_PLAY, 0, 0, 0, 8000, 0));
		pending_words.push_back(mk(OP_PLAY_AUTO, 0, 128, 0, 22050, 0));
		pending_words.push_back(mk(OP_FREQ, 3, 0, 0, 1, 0));
		pending_words.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
		pending_words.push_back(mk(4'd15, 0, 0, 0, 0, 0));
		drain();
		write_cfg(CFG_FIRST_AUTO, 4'd8);
		pending_words.push_back(mk(OP_PLAY_AUTO, 0, 9, 0, 100, 0));
		drain();
		write_cfg(CFG_CHANNEL_COUNT, 4'd2);
		write_cfg(CFG_FIRST_AUTO, 4'd1);
		for (int k = 0; k < 4; k++)
			pending_words.push_back(mk(OP_PLAY_AUTO, 0, 200, 0, 1000 + k, 0));
		pending_words.push_back(mk(OP_PLAY, 6, 0, 0, 5, 0));
		drain();
		// random phases over several settings
		for (int phase = 0; phase < 6; phase++) begin
			int cc, fa;
			cc = (phase == 0) ? 0 : (phase == 1) ? 15 : (phase == 2) ? 1 : $urandom_range(0, 15);
			fa = (phase == 3) ? 15 : $urandom_range(0, 8);
			write_cfg(CFG_CHANNEL_COUNT, 4'(cc));
			write_cfg(CFG_FIRST_AUTO, 4'(fa));
			for (int k = 0; k < 100; k++) pending_words.push_back(rand_event());
			if (phase == 2) begin
				wait (sent > 0);
				hold_off = 1;
				repeat (800) @(posedge clk);
				hold_off = 0;
			end
			if (phase == 4) begin
				wait (pending_words.size() < 50);
				sender_pause = 1;
				wait (expected_words.size() == 0);
				sender_pause = 0;
			end
			drain();
		end
		if (mismatches == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/mrdam_pkg.sv
rtl/mrdam_div.sv
rtl/multichannel_rate_divided_audio_mixer_unit.sv
rtl/mrdam_chk.sv
sim/tb.sv
